// ===== hdl/sfcu_pkg.sv =====
// ----------------------------------------------------------------------------
// Script flow control unit package
// Shared constants, operation codes and the stack command type.
// ----------------------------------------------------------------------------
package sfcu_pkg;

    // Default return stack depth
    localparam int STACK_ENTRIES_DEF = 4;

    // Operation selector (low nibble of opcodes 0xF2..0xFF)
    localparam logic [3:0] MODE_END       = 4'hF;
    localparam logic [3:0] MODE_YIELD     = 4'hE;
    localparam logic [3:0] MODE_WAIT      = 4'hD;
    localparam logic [3:0] MODE_CALL      = 4'hC;
    localparam logic [3:0] MODE_JUMP      = 4'hB;
    localparam logic [3:0] MODE_JUMP_Z    = 4'hA;
    localparam logic [3:0] MODE_JUMP_N    = 4'h9;
    localparam logic [3:0] MODE_LOOP      = 4'h8;
    localparam logic [3:0] MODE_LOOP_END  = 4'h7;
    localparam logic [3:0] MODE_BREAK     = 4'h6;
    localparam logic [3:0] MODE_JUMP_NN   = 4'h5;
    localparam logic [3:0] MODE_REL       = 4'h4;
    localparam logic [3:0] MODE_REL_Z     = 4'h3;
    localparam logic [3:0] MODE_REL_N     = 4'h2;

    // Outcome codes
    localparam logic [1:0] OUT_CONTINUE = 2'd0;
    localparam logic [1:0] OUT_ENDED    = 2'd1;
    localparam logic [1:0] OUT_WAIT     = 2'd2;
    localparam logic [1:0] OUT_FAULT    = 2'd3;

    // Yield waits one tick
    localparam logic [14:0] YIELD_DELAY = 15'd1;

    // Stack update request from the execute logic
    typedef struct packed {
        logic        push;          // push return address
        logic        pop;           // drop top entry
        logic        count_wr;      // write a loop count
        logic        count_at_top;  // count goes to top entry (else to new entry)
        logic [7:0]  count_val;
        logic [15:0] push_addr;
    } stk_cmd_t;

endpackage

// ===== hdl/sfcu_op_if.sv =====
// ----------------------------------------------------------------------------
// Operation channel
// Valid/ready channel carrying one flow-control operation per transaction.
// ----------------------------------------------------------------------------
interface sfcu_op_if;
    logic              valid;
    logic              ready;
    logic [3:0]        mode;
    logic [15:0]       arg;
    logic signed [7:0] script_value;
    logic [15:0]       pc;
    logic [7:0]        first_byte;
    logic [7:0]        second_byte;

    modport source (
        output valid, mode, arg, script_value, pc, first_byte, second_byte,
        input  ready
    );

    modport sink (
        input  valid, mode, arg, script_value, pc, first_byte, second_byte,
        output ready
    );
endinterface

// ===== hdl/sfcu_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one operation result per transaction.
// ----------------------------------------------------------------------------
interface sfcu_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_pc;
    logic [1:0]  outcome;
    logic [14:0] delay;
    logic [2:0]  stack_depth;

    modport source (
        output valid, next_pc, outcome, delay, stack_depth,
        input  ready
    );

    modport sink (
        input  valid, next_pc, outcome, delay, stack_depth,
        output ready
    );
endinterface

// ===== hdl/sfcu_stack.sv =====
// ----------------------------------------------------------------------------
// Return stack
// Register stack of return addresses and loop counts with a level counter.
// ----------------------------------------------------------------------------
module sfcu_stack #(
    parameter int STACK_ENTRIES = sfcu_pkg::STACK_ENTRIES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sfcu_pkg::stk_cmd_t                     cmd,
    output logic [15:0]                            top_addr,
    output logic [7:0]                             top_count,
    output logic                                   empty,
    output logic                                   full,
    output logic [$clog2(STACK_ENTRIES+1)-1:0]     level_next
);
    localparam int LVL_W = $clog2(STACK_ENTRIES + 1);
    localparam int IDX_W = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

    logic [15:0]      ret_reg [STACK_ENTRIES];
    logic [7:0]       cnt_reg [STACK_ENTRIES];
    logic [LVL_W-1:0] level_reg;
    logic [IDX_W-1:0] top_idx;
    logic [IDX_W-1:0] push_idx;
    logic [IDX_W-1:0] cnt_idx;

    // Entry pointers
    assign top_idx  = IDX_W'(level_reg - LVL_W'(1));
    assign push_idx = IDX_W'(level_reg);
    assign cnt_idx  = cmd.count_at_top ? top_idx : push_idx;

    // Status and top-of-stack read
    assign empty     = (level_reg == '0);
    assign full      = (level_reg == LVL_W'(STACK_ENTRIES));
    assign top_addr  = ret_reg[top_idx];
    assign top_count = cnt_reg[top_idx];

    // Level after this cycle's command
    always_comb
    begin
        level_next = level_reg;
        if (cmd.push)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (cmd.pop)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    // Level counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    // Entry storage, undefined until written
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ret_reg[push_idx] <= cmd.push_addr;
        end
        if (cmd.count_wr)
        begin
            cnt_reg[cnt_idx] <= cmd.count_val;
        end
    end

`ifndef NO_ASSERTIONS
    // Push only below capacity, pop only above zero
    assert property (@(posedge clk) disable iff (!rst_n) cmd.push |-> !full)
        else $error("push on full stack");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.pop |-> !empty)
        else $error("pop on empty stack");
    // Never both in one cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.push && cmd.pop))
        else $error("push and pop together");
`endif
endmodule

// ===== hdl/sfcu_exec.sv =====
// ----------------------------------------------------------------------------
// Flow-control execute logic
// Decodes one operation and forms next counter, outcome, delay and stack cmd.
// ----------------------------------------------------------------------------
module sfcu_exec (
    input  logic [3:0]          mode,
    input  logic [15:0]         arg,
    input  logic signed [7:0]   script_value,
    input  logic [15:0]         pc,
    input  logic [7:0]          first_byte,
    input  logic [7:0]          second_byte,
    input  logic [15:0]         script_base,
    input  logic [15:0]         top_addr,
    input  logic [7:0]          top_count,
    input  logic                empty,
    input  logic                full,
    output logic [15:0]         next_pc,
    output logic [1:0]          outcome,
    output logic [14:0]         delay,
    output sfcu_pkg::stk_cmd_t  cmd
);
    logic        is_zero;
    logic        is_neg;
    logic [15:0] abs_target;
    logic [15:0] rel_target;
    logic [14:0] wait_delay;
    logic [15:0] wait_pc;
    logic [7:0]  count_dec;

    // Conditions and targets
    assign is_zero    = (script_value == 8'sd0);
    assign is_neg     = script_value[7];
    assign abs_target = script_base + arg;
    assign rel_target = pc + {{8{arg[7]}}, arg[7:0]};
    assign count_dec  = top_count - 8'd1;

    // Compressed delay: one byte, or two when the top bit is set
    always_comb
    begin
        if (first_byte[7])
        begin
            wait_delay = {first_byte[6:0], second_byte};
            wait_pc    = pc + 16'd2;
        end
        else
        begin
            wait_delay = {7'd0, first_byte};
            wait_pc    = pc + 16'd1;
        end
    end

    // Operation decode
    always_comb
    begin
        next_pc          = pc;
        outcome          = sfcu_pkg::OUT_CONTINUE;
        delay            = '0;
        cmd.push         = 1'b0;
        cmd.pop          = 1'b0;
        cmd.count_wr     = 1'b0;
        cmd.count_at_top = 1'b0;
        cmd.count_val    = arg[7:0];
        cmd.push_addr    = pc;
        case (mode)
            sfcu_pkg::MODE_END:
            begin
                if (empty)
                begin
                    outcome = sfcu_pkg::OUT_ENDED;
                end
                else
                begin
                    cmd.pop = 1'b1;
                    next_pc = top_addr;
                end
            end
            sfcu_pkg::MODE_YIELD:
            begin
                outcome = sfcu_pkg::OUT_WAIT;
                delay   = sfcu_pkg::YIELD_DELAY;
            end
            sfcu_pkg::MODE_WAIT:
            begin
                next_pc = wait_pc;
                if (wait_delay != '0)
                begin
                    outcome = sfcu_pkg::OUT_WAIT;
                    delay   = wait_delay;
                end
            end
            sfcu_pkg::MODE_CALL:
            begin
                if (full)
                begin
                    outcome = sfcu_pkg::OUT_FAULT;
                end
                else
                begin
                    cmd.push = 1'b1;
                    next_pc  = abs_target;
                end
            end
            sfcu_pkg::MODE_LOOP:
            begin
                if (full)
                begin
                    outcome = sfcu_pkg::OUT_FAULT;
                end
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.count_wr = 1'b1;
                end
            end
            sfcu_pkg::MODE_LOOP_END:
            begin
                if (empty)
                begin
                    outcome = sfcu_pkg::OUT_FAULT;
                end
                else
                begin
                    cmd.count_wr     = 1'b1;
                    cmd.count_at_top = 1'b1;
                    cmd.count_val    = count_dec;
                    if (count_dec != 8'd0)
                    begin
                        next_pc = top_addr;
                    end
                    else
                    begin
                        cmd.pop = 1'b1;
                    end
                end
            end
            sfcu_pkg::MODE_BREAK:
            begin
                if (empty)
                begin
                    outcome = sfcu_pkg::OUT_FAULT;
                end
                else
                begin
                    cmd.pop = 1'b1;
                end
            end
            sfcu_pkg::MODE_JUMP:
            begin
                next_pc = abs_target;
            end
            sfcu_pkg::MODE_JUMP_Z:
            begin
                if (is_zero)
                begin
                    next_pc = abs_target;
                end
            end
            sfcu_pkg::MODE_JUMP_N:
            begin
                if (is_neg)
                begin
                    next_pc = abs_target;
                end
            end
            sfcu_pkg::MODE_JUMP_NN:
            begin
                if (!is_neg)
                begin
                    next_pc = abs_target;
                end
            end
            sfcu_pkg::MODE_REL:
            begin
                next_pc = rel_target;
            end
            sfcu_pkg::MODE_REL_Z:
            begin
                if (is_zero)
                begin
                    next_pc = rel_target;
                end
            end
            sfcu_pkg::MODE_REL_N:
            begin
                if (is_neg)
                begin
                    next_pc = rel_target;
                end
            end
            default:
            begin
                next_pc = pc;
            end
        endcase
    end
endmodule

// ===== hdl/script_flow_control_unit.sv =====
// ----------------------------------------------------------------------------
// Script flow control unit
// Usage:
//   op  : sink channel, one flow-control operation per transaction
//         (mode, arg, script_value, pc and the two script bytes at pc).
//   res : source channel, exactly one result per operation, in order
//         (next_pc, outcome, delay, stack_depth).
//   cfg_we / cfg_wdata : writes script_base; write only while idle.
//   Registers: a taken operation is captured in the input register, then moves
//   into the result register once that register is empty or res.ready is high.
//   Throughput: one operation per cycle while res.ready is high. The stack
//   update happens as the operation moves into the result register, so the
//   next operation sees the new stack in the following cycle.
//   Stalls: when res.ready is low the result is held; one more operation
//   can sit in the input register, after which op.ready drops.
//   Reset: clears the stack level, script_base and both valid flags.
//   Stack entries hold no reset value; a call or loop start writes them.
// ----------------------------------------------------------------------------
module script_flow_control_unit #(
    parameter int STACK_ENTRIES = sfcu_pkg::STACK_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sfcu_op_if.sink     op,
    sfcu_res_if.source  res,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    localparam int LVL_W = $clog2(STACK_ENTRIES + 1);

    // Input register
    logic              stg_valid_reg;
    logic [3:0]        mode_reg;
    logic [15:0]       arg_reg;
    logic signed [7:0] value_reg;
    logic [15:0]       pc_reg;
    logic [7:0]        byte0_reg;
    logic [7:0]        byte1_reg;

    // Result register
    logic        res_valid_reg;
    logic [15:0] next_pc_reg;
    logic [1:0]  outcome_reg;
    logic [14:0] delay_reg;
    logic [2:0]  depth_reg;

    logic [15:0] script_base_reg;

    logic               advance;
    logic               fire;
    logic               take;
    logic [15:0]        ex_next_pc;
    logic [1:0]         ex_outcome;
    logic [14:0]        ex_delay;
    sfcu_pkg::stk_cmd_t ex_cmd;
    sfcu_pkg::stk_cmd_t stk_cmd;
    logic [15:0]        top_addr;
    logic [7:0]         top_count;
    logic               stk_empty;
    logic               stk_full;
    logic [LVL_W-1:0]   level_next;

    // Handshake
    assign advance  = !res_valid_reg || res.ready;
    assign fire     = stg_valid_reg && advance;
    assign op.ready = !stg_valid_reg || advance;
    assign take     = op.valid && op.ready;

    // Stack changes only when the operation retires
    always_comb
    begin
        stk_cmd          = ex_cmd;
        stk_cmd.push     = ex_cmd.push && fire;
        stk_cmd.pop      = ex_cmd.pop && fire;
        stk_cmd.count_wr = ex_cmd.count_wr && fire;
    end

    sfcu_exec u_exec (
        .mode         (mode_reg),
        .arg          (arg_reg),
        .script_value (value_reg),
        .pc           (pc_reg),
        .first_byte   (byte0_reg),
        .second_byte  (byte1_reg),
        .script_base  (script_base_reg),
        .top_addr     (top_addr),
        .top_count    (top_count),
        .empty        (stk_empty),
        .full         (stk_full),
        .next_pc      (ex_next_pc),
        .outcome      (ex_outcome),
        .delay        (ex_delay),
        .cmd          (ex_cmd)
    );

    sfcu_stack #(
        .STACK_ENTRIES (STACK_ENTRIES)
    ) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (stk_cmd),
        .top_addr   (top_addr),
        .top_count  (top_count),
        .empty      (stk_empty),
        .full       (stk_full),
        .level_next (level_next)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
            script_base_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                stg_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                stg_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                script_base_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg  <= op.mode;
            arg_reg   <= op.arg;
            value_reg <= op.script_value;
            pc_reg    <= op.pc;
            byte0_reg <= op.first_byte;
            byte1_reg <= op.second_byte;
        end
        if (fire)
        begin
            next_pc_reg <= ex_next_pc;
            outcome_reg <= ex_outcome;
            delay_reg   <= ex_delay;
            depth_reg   <= 3'(level_next);
        end
    end

    // Result channel
    assign res.valid       = res_valid_reg;
    assign res.next_pc     = next_pc_reg;
    assign res.outcome     = outcome_reg;
    assign res.delay       = delay_reg;
    assign res.stack_depth = depth_reg;

`ifndef NO_ASSERTIONS
    // Empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n) !res_valid_reg |-> op.ready)
        else $error("input stalled with empty result register");
    // Delay is nonzero only for a wait
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && ex_outcome != sfcu_pkg::OUT_WAIT |=> delay_reg == '0)
        else $error("delay on a non-wait result");
    // A fault leaves the stack depth unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && ex_outcome == sfcu_pkg::OUT_FAULT |-> !stk_cmd.push && !stk_cmd.pop)
        else $error("stack changed on fault");
    // A stalled result does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |=> $stable(next_pc_reg) && $stable(outcome_reg))
        else $error("held result changed");
`endif
endmodule
